// ===== hw/rtl/cbt_pkg.sv =====
// Package for the charset byte translator: item types, table geometry and codes.
// Used by every module of the translator; depends on nothing else.
package cbt_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 128;
    localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Entry first bytes from 2 up to this value are reserved and emit nothing.
    localparam logic [7:0] RESERVED_MAX = 8'd32;

    // Operation codes.
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_LOAD      = 1'b1;

    // Translation level codes.
    typedef logic [1:0] level_t;
    localparam level_t LEVEL_LOW  = 2'd1;
    localparam level_t LEVEL_HIGH = 2'd2;

    // One input transfer.
    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic [6:0] entry_index;
        logic [7:0] entry_first;
        logic [7:0] entry_second;
    } in_item_t;

    // One result transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // A classified translation waiting for the back end: one or two bytes.
    typedef struct packed {
        logic       two;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } pair_t;

endpackage

// ===== hw/rtl/cbt_front.sv =====
// Front end of the charset byte translator: accepts items, holds the pair table,
// classifies each translated byte and pushes the bytes to emit. Depends on cbt_pkg.
module cbt_front import cbt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  level_t   level,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     push_valid,
    input  logic     push_ready,
    output pair_t    push_item
);

    logic [15:0]          table_mem [TABLE_DEPTH];
    logic [15:0]          rdata_reg;
    logic                 st1_valid_reg;
    logic                 pass_reg;
    logic [7:0]           byte_reg;
    logic                 s_accept;
    logic                 hit;
    logic                 emit;
    logic                 st1_go;
    logic [7:0]           first_b;
    logic [7:0]           second_b;
    logic [TBL_IDX_W-1:0] rd_idx;

    assign s_accept = s_valid && s_ready;
    assign rd_idx   = s_data.data_byte[TBL_IDX_W-1:0];

    // A byte is looked up only when its half of the range is selected by the level.
    assign hit = ((level == LEVEL_LOW) && !s_data.data_byte[7]) ||
                 ((level == LEVEL_HIGH) && s_data.data_byte[7]);

    // Table writes and the registered lookup both happen on the input transfer.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_data.operation == OP_LOAD)) begin
            table_mem[s_data.entry_index] <= {s_data.entry_first, s_data.entry_second};
        end
        if (s_accept && (s_data.operation == OP_TRANSLATE)) begin
            rdata_reg <= table_mem[rd_idx];
        end
    end

    // Lookup stage: holds one translate item until its bytes reach the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st1_valid_reg <= (s_data.operation == OP_TRANSLATE);
        end else if (st1_go) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && (s_data.operation == OP_TRANSLATE)) begin
            pass_reg <= !hit;
            byte_reg <= s_data.data_byte;
        end
    end

    assign first_b  = rdata_reg[15:8];
    assign second_b = rdata_reg[7:0];

    // Classify the entry into no byte, one byte or a pair.
    always_comb begin
        emit      = 1'b0;
        push_item = '0;
        if (pass_reg) begin
            emit                  = 1'b1;
            push_item.second_byte = byte_reg;
        end else if (first_b inside {8'd0, 8'd1}) begin
            emit                  = (second_b != 8'd0);
            push_item.second_byte = second_b;
        end else if (first_b inside {[8'd2:RESERVED_MAX]}) begin
            emit = 1'b0;
        end else begin
            emit                  = 1'b1;
            push_item.two         = 1'b1;
            push_item.first_byte  = first_b;
            push_item.second_byte = second_b;
        end
    end

    // An item that emits nothing leaves the stage without using the queue.
    assign push_valid = st1_valid_reg && emit;
    assign st1_go     = st1_valid_reg && (!emit || push_ready);
    assign s_ready    = !st1_valid_reg || st1_go;

endmodule

// ===== hw/rtl/cbt_queue.sv =====
// Short queue between front and back of the charset byte translator.
// Holds classified byte pairs; depends on cbt_pkg. DEPTH must be at least 2.
module cbt_queue import cbt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  pair_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output pair_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pair_t            slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage is written at the tail only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers wrap at DEPTH; the count tracks occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/cbt_back.sv =====
// Back end of the charset byte translator: emits the queued bytes one per transfer
// through an output register and marks the final byte. Depends on cbt_pkg.
module cbt_back import cbt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  pair_t     pop_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      m_valid_reg;
    out_item_t m_data_reg;
    logic      phase_reg;
    logic      load;
    logic      first_half;

    // The output register takes a new byte whenever it is empty or being drained.
    assign load       = pop_valid && (!m_valid_reg || m_ready);
    assign first_half = pop_item.two && !phase_reg;
    assign pop_ready  = load && !first_half;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                phase_reg   <= first_half;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // A pair sends its first byte without the last flag, then its second byte.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.out_byte <= first_half ? pop_item.first_byte : pop_item.second_byte;
            m_data_reg.last     <= !first_half;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/charset_byte_translator.sv =====
// Top level of the charset byte translator: configuration register, front, queue, back.
// Depends on cbt_pkg, cbt_front, cbt_queue and cbt_back.
//
// The translator maps a byte stream through a 128-entry table of byte pairs. A load
// item writes one entry and produces nothing; a translate item produces zero, one or
// two output bytes, the final one flagged with last. The level register at APB
// address 0 picks the translated half: 1 for bytes below 128, 2 for bytes of 128 and
// up, anything else passes every byte through. The front takes one item per cycle while
// the queue has room and looks it up in the table; the back sends one byte per cycle
// through its output register while the receiver is ready, so an item takes one output
// transfer per byte it yields: one, none or two. The output register sets the
// sustained rate. An item's bytes pass the lookup register, the queue and the output
// register. Entries must be loaded before any byte that reads them is translated.
module charset_byte_translator import cbt_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    level_t level_reg;
    logic   q_push_valid;
    logic   q_push_ready;
    pair_t  q_push_item;
    logic   q_pop_valid;
    logic   q_pop_ready;
    pair_t  q_pop_item;
    logic   unused_addr;

    // The single register fills the whole address space of the port.
    assign unused_addr = ^paddr;

    // Level register, written on the access phase of an APB write transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            level_reg <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_W - 2){1'b0}}, level_reg};

    cbt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .level      (level_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    cbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    cbt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_item  (q_pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A load transfer leaves nothing behind for the queue in the next cycle.
    a_load_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.operation == OP_LOAD) && !unused_addr) ||
        (s_valid && s_ready && (s_data.operation == OP_LOAD) && unused_addr)
        |=> !q_push_valid)
        else $error("push after a load transfer");

    // The input stalls only when the queue is full.
    a_stall_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> !q_push_ready)
        else $error("input stalled while queue has room");

    // The first byte of a pair is always followed at once by its final byte.
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=> (m_valid && m_data.last))
        else $error("second byte of a pair missing");

endmodule

// ===== dv/cbt_tb_pkg.sv =====
// Scoreboard for the charset byte translator testbench: predicts output bytes and checks them.
// Depends on cbt_pkg for the transfer types, the codes and the table geometry.
`timescale 1ns / 100ps

package cbt_tb_pkg;
    import cbt_pkg::*;

    class translation_scoreboard;
        logic [15:0] pair_copy [TABLE_DEPTH];
        level_t      level;
        out_item_t   expected_bytes [$];
        int          errors;

        function new();
            foreach (pair_copy[i]) pair_copy[i] = '0;
            level  = '0;
            errors = 0;
        endfunction

        // Follows a level register write seen on the configuration port.
        function void set_level(logic [APB_DATA_W-1:0] value);
            level = value[1:0];
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Prints one line per mismatch and counts it.
        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Updates the table copy for a load, or queues the bytes a translate produces.
        function void note_input(in_item_t it);
            logic        looked_up;
            logic [15:0] entry;
            out_item_t   ob;
            if (it.operation == OP_LOAD) begin
                pair_copy[it.entry_index] = {it.entry_first, it.entry_second};
                return;
            end
            looked_up = (level == LEVEL_LOW && !it.data_byte[7]) ||
                        (level == LEVEL_HIGH && it.data_byte[7]);
            if (!looked_up) begin
                ob.out_byte = it.data_byte;
                ob.last     = 1'b1;
                expected_bytes.push_back(ob);
                return;
            end
            entry = pair_copy[it.data_byte[6:0]];
            if (entry[15:8] <= 8'd1) begin
                // Single-byte entry; a zero second byte means the byte is dropped.
                if (entry[7:0] != 8'd0) begin
                    ob.out_byte = entry[7:0];
                    ob.last     = 1'b1;
                    expected_bytes.push_back(ob);
                end
            end else if (entry[15:8] > RESERVED_MAX) begin
                ob.out_byte = entry[15:8];
                ob.last     = 1'b0;
                expected_bytes.push_back(ob);
                ob.out_byte = entry[7:0];
                ob.last     = 1'b1;
                expected_bytes.push_back(ob);
            end
        endfunction

        // Compares one output transfer with the oldest expected byte.
        task check_result(out_item_t got);
            out_item_t exp_item;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected output byte %02h last %0b",
                                 got.out_byte, got.last));
                return;
            end
            exp_item = expected_bytes.pop_front();
            if (got.out_byte !== exp_item.out_byte)
                report($sformatf("out_byte %02h, expected %02h", got.out_byte, exp_item.out_byte));
            if (got.last !== exp_item.last)
                report($sformatf("last %0b on byte %02h, expected %0b",
                                 got.last, got.out_byte, exp_item.last));
        endtask
    endclass

endpackage

// ===== dv/tb_charset_byte_translator.sv =====
// Top-level testbench for the charset byte translator: drives loads, translations and level writes.
// Depends on cbt_pkg, cbt_tb_pkg and the charset_byte_translator RTL.
`timescale 1ns / 100ps

module tb_charset_byte_translator;
    import cbt_pkg::*;
    import cbt_tb_pkg::*;

    localparam level_t                LEVEL_OFF      = 2'd0;
    localparam level_t                LEVEL_PASS     = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_LEVEL     = '0;
    localparam int                    LONG_HOLD      = 80;
    localparam int                    DRAIN_CYCLES   = 8;
    localparam int                    WATCHDOG_LIMIT = 2000;
    localparam int                    PHASE_ITEMS    = 185;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;

    translation_scoreboard sb = new();

    // Generator view of the table and the level, used to avoid reading unloaded entries.
    bit     loaded [TABLE_DEPTH];
    level_t cur_level;

    bit idle_en;
    int hold_req;
    int hold_seen;
    int stall_left;
    int quiet_cycles;

    charset_byte_translator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Monitor: every accepted transfer goes to the scoreboard at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == ADDR_LEVEL)
                sb.set_level(pwdata);
            if (s_valid && s_ready)
                sb.note_input(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Receiver: random short stalls, plus a long hold-off whenever one is requested.
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen  = hold_req;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one input item, with an occasional idle burst first, and waits for its transfer.
    task automatic send_item(input in_item_t it);
        int gap;
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
    endtask

    task automatic load_entry(input logic [6:0] idx, input logic [7:0] first,
                              input logic [7:0] second);
        in_item_t it;
        it              = in_item_t'($urandom);
        it.operation    = OP_LOAD;
        it.entry_index  = idx;
        it.entry_first  = first;
        it.entry_second = second;
        loaded[idx]     = 1'b1;
        send_item(it);
    endtask

    // Loads an entry with content drawn from every class of first byte.
    task automatic load_random_entry(input logic [6:0] idx);
        logic [7:0] first;
        logic [7:0] second;
        second = 8'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                first  = 8'($urandom_range(0, 1));
                second = ($urandom_range(0, 2) == 0) ? 8'd0 : second;
            end
            1: first = 8'($urandom_range(2, 32));
            default: first = 8'($urandom_range(33, 255));
        endcase
        load_entry(idx, first, second);
    endtask

    // Translates one byte; an entry the byte would read is loaded first if it never was.
    task automatic translate_byte(input logic [7:0] b);
        in_item_t it;
        if (((cur_level == LEVEL_LOW && !b[7]) || (cur_level == LEVEL_HIGH && b[7]))
                && !loaded[b[6:0]])
            load_random_entry(b[6:0]);
        it           = in_item_t'($urandom);
        it.operation = OP_TRANSLATE;
        it.data_byte = b;
        send_item(it);
    endtask

    // Waits for every expected byte, then lets loads or empty translations in flight finish.
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the level register, then reads it back.
    task automatic write_level(input level_t lv);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LEVEL;
        pwdata  <= APB_DATA_W'(lv);
        @(negedge aclk);
        penable <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        if (prdata[1:0] !== lv)
            sb.report($sformatf("level reads back %0d, expected %0d", prdata[1:0], lv));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_level = lv;
    endtask

    // One random item: mostly translations, some loads to keep the table changing.
    task automatic random_item();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 20) begin
            load_random_entry(7'($urandom_range(0, TABLE_DEPTH - 1)));
        end else begin
            b = 8'($urandom);
            // Half the time, aim at the half of the byte range that is looked up.
            if ($urandom_range(0, 1) == 0) begin
                if (cur_level == LEVEL_LOW) b[7] = 1'b0;
                else if (cur_level == LEVEL_HIGH) b[7] = 1'b1;
            end
            translate_byte(b);
        end
    endtask

    initial begin
        level_t lv;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        idle_en    = 1'b1;
        hold_req   = 0;
        cur_level  = LEVEL_OFF;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset level passes everything through; loads cover every entry class.
        translate_byte(8'h00);
        translate_byte(8'hFF);
        translate_byte(8'h80);
        translate_byte(8'h7F);
        load_entry(7'd0, 8'h00, 8'h00);
        load_entry(7'd1, 8'h00, 8'h41);
        load_entry(7'd2, 8'h01, 8'h00);
        load_entry(7'd3, 8'h01, 8'hFF);
        load_entry(7'd4, 8'h02, 8'h55);
        load_entry(7'd5, 8'h20, 8'h66);
        load_entry(7'd6, 8'h21, 8'h00);
        load_entry(7'd127, 8'hFF, 8'hFF);

        // Low half translated: empty, single, reserved and pair entries.
        wait_drain();
        write_level(LEVEL_LOW);
        for (int i = 0; i < 7; i++) translate_byte(8'(i));
        translate_byte(8'h7F);
        translate_byte(8'h80);
        translate_byte(8'hFF);

        // High half translated through the same entries.
        wait_drain();
        write_level(LEVEL_HIGH);
        translate_byte(8'h80);
        translate_byte(8'h81);
        translate_byte(8'hFF);
        translate_byte(8'h00);

        // Level 3 passes everything through.
        wait_drain();
        write_level(LEVEL_PASS);
        translate_byte(8'h05);
        translate_byte(8'h85);

        // Random phases, each at its own level; the last one runs without idling.
        for (int ph = 0; ph < 8; ph++) begin
            wait_drain();
            case (ph)
                0: lv = LEVEL_LOW;
                1: lv = LEVEL_HIGH;
                2: lv = LEVEL_OFF;
                3: lv = LEVEL_PASS;
                default: lv = level_t'($urandom_range(0, 3));
            endcase
            if (ph >= 6 && lv != LEVEL_LOW && lv != LEVEL_HIGH)
                lv = (ph == 6) ? LEVEL_LOW : LEVEL_HIGH;
            write_level(lv);
            idle_en = (ph == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (ph == 1 || ph == 5) idle_en = 1'b1;
            // Long receiver hold-off so the block fills and pushes back on its input.
            if (ph == 1) hold_req++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Sender pause until the block has delivered everything.
                if (ph == 5 && n == PHASE_ITEMS / 2) wait_drain();
                random_item();
            end
        end

        wait_drain();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected bytes never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cbt_pkg.sv
hw/rtl/cbt_front.sv
hw/rtl/cbt_queue.sv
hw/rtl/cbt_back.sv
hw/rtl/charset_byte_translator.sv
dv/cbt_tb_pkg.sv
dv/tb_charset_byte_translator.sv
